// File: hw/rtl/hrf_pkg.sv
// Types and constants shared by the HTTP request framer.
// No dependencies; imported by hrf_core and http_request_framer_top.
`default_nettype none

package hrf_pkg;

    // Buffer capacity after reset, in bytes.
    localparam logic [15:0] LIMIT_RESET = 16'd4096;
    // Number of characters in the matched header name.
    localparam logic [3:0]  NAME_LEN    = 4'd15;
    // Distance between upper and lower case letters.
    localparam logic [7:0]  CASE_GAP    = 8'd32;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UPA   = 8'h41;
    localparam logic [7:0] CH_UPZ   = 8'h5A;

    typedef enum logic [1:0] {
        PH_HEADERS = 2'd0,
        PH_BODY    = 2'd1,
        PH_DONE    = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        LP_SEARCH = 2'd0,
        LP_BLANKS = 2'd1,
        LP_DIGITS = 2'd2,
        LP_DONE   = 2'd3
    } t_len_phase;

    typedef enum logic [2:0] {
        V_PENDING   = 3'd0,
        V_COMPLETE  = 3'd1,
        V_TOO_LARGE = 3'd2,
        V_HDR_OVF   = 3'd3,
        V_IGNORED   = 3'd4
    } t_verdict;

    // One input word as held in the input register.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } t_in_item;

    // One result word.
    typedef struct packed {
        logic [15:0] bytes_seen;
        logic [31:0] body_length;
        logic [15:0] header_length;
        t_verdict    verdict;
    } t_result;

    // Lower-case characters of "content-length:" by position.
    function automatic logic [7:0] name_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h63; // c
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h6C; // l
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hrf_core.sv
// Per-request framing state and the single-pass step logic for one word.
// Depends on hrf_pkg for types, enums and the header name table.
`default_nettype none

module hrf_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_advance,
    input  wire hrf_pkg::t_in_item i_item,
    input  wire logic [15:0]       i_limit,
    output hrf_pkg::t_result       o_result
);
    import hrf_pkg::*;

    t_phase      r_phase;
    logic [15:0] r_bt;
    logic [1:0]  r_cp;
    logic [3:0]  r_np;
    t_len_phase  r_lp;
    logic [31:0] r_lv;
    logic [15:0] r_bo;

    // State as seen by this word, after an optional restart.
    t_phase      s_phase;
    logic [15:0] s_bt;
    logic [1:0]  s_cp;
    logic [3:0]  s_np;
    t_len_phase  s_lp;
    logic [31:0] s_lv;
    logic [15:0] s_bo;

    t_phase      n_phase;
    logic [15:0] n_bt;
    logic [1:0]  n_cp;
    logic [3:0]  n_np;
    t_len_phase  n_lp;
    logic [31:0] n_lv;
    logic [15:0] n_bo;

    logic [7:0]  w_b;
    logic [7:0]  w_fold;
    logic        w_is_digit;
    logic [31:0] w_digit;
    logic [35:0] w_acc;
    logic        w_hdr_end;
    logic [32:0] w_need;
    logic        w_got_all;
    logic        w_too_big;
    logic        w_ovf;
    t_verdict    w_verdict;

    assign w_b        = i_item.data_byte;
    assign w_fold     = (w_b >= CH_UPA && w_b <= CH_UPZ) ? w_b + CASE_GAP : w_b;
    assign w_is_digit = (w_b >= CH_ZERO) && (w_b <= CH_NINE);
    assign w_digit    = {24'd0, w_b - CH_ZERO};
    // Times ten as two shifted copies, plus the new digit.
    assign w_acc      = {1'b0, r_lv, 3'd0} + {3'd0, r_lv, 1'b0} + {4'd0, w_digit};

    // A set first-byte flag clears the request before this word is taken.
    always_comb begin
        if (i_item.first_byte) begin
            s_phase = PH_HEADERS;
            s_bt    = 16'd0;
            s_cp    = 2'd0;
            s_np    = 4'd0;
            s_lp    = LP_SEARCH;
            s_lv    = 32'd0;
            s_bo    = 16'd0;
        end else begin
            s_phase = r_phase;
            s_bt    = r_bt;
            s_cp    = r_cp;
            s_np    = r_np;
            s_lp    = r_lp;
            s_lv    = r_lv;
            s_bo    = r_bo;
        end
    end

    // Byte count, header name match, length digits and the CRLFCRLF search.
    always_comb begin
        n_bt      = s_bt;
        n_cp      = s_cp;
        n_np      = s_np;
        n_lp      = s_lp;
        n_lv      = s_lv;
        n_bo      = s_bo;
        w_hdr_end = 1'b0;
        if (s_phase != PH_DONE) begin
            n_bt = (s_bt == 16'hFFFF) ? s_bt : s_bt + 16'd1;
        end
        if (s_phase == PH_HEADERS) begin
            case (s_lp)
                LP_SEARCH: begin
                    if (s_np < NAME_LEN && w_fold == name_char(s_np)) begin
                        n_np = s_np + 4'd1;
                        if (s_np + 4'd1 == NAME_LEN) begin
                            n_lp = LP_BLANKS;
                        end
                    end else begin
                        n_np = (w_fold == name_char(4'd0)) ? 4'd1 : 4'd0;
                    end
                end
                LP_BLANKS: begin
                    if (w_b == CH_SPACE || w_b == CH_TAB) begin
                        n_lp = LP_BLANKS;
                    end else if (w_is_digit) begin
                        n_lv = w_digit;
                        n_lp = LP_DIGITS;
                    end else begin
                        n_lp = LP_DONE;
                    end
                end
                LP_DIGITS: begin
                    if (w_is_digit) begin
                        n_lv = (w_acc[35:32] != 4'd0) ? 32'hFFFF_FFFF : w_acc[31:0];
                    end else begin
                        n_lp = LP_DONE;
                    end
                end
                default: begin
                    n_lp = s_lp;
                end
            endcase

            if (w_b == CH_CR) begin
                n_cp = (s_cp == 2'd2) ? 2'd3 : 2'd1;
            end else if (w_b == CH_LF) begin
                if (s_cp == 2'd3) begin
                    n_cp      = 2'd0;
                    w_hdr_end = 1'b1;
                end else begin
                    n_cp = (s_cp == 2'd1) ? 2'd2 : 2'd0;
                end
            end else begin
                n_cp = 2'd0;
            end

            // At the header end a name matched but without digits counts as absent.
            if (w_hdr_end) begin
                n_bo = n_bt;
                if (n_lp == LP_BLANKS) begin
                    n_lp = LP_DONE;
                end
            end
        end
    end

    // Size checks: total need against bytes taken and against the limit, and header bytes against the limit.
    assign w_need    = {1'b0, 16'd0, n_bo} + {1'b0, n_lv};
    assign w_got_all = {17'd0, n_bt} >= w_need;
    assign w_too_big = w_need >= {17'd0, i_limit};
    assign w_ovf     = ({1'b0, n_bt} + 17'd1) >= {1'b0, i_limit};

    // Next phase.
    always_comb begin
        n_phase = s_phase;
        case (s_phase)
            PH_HEADERS: begin
                if (w_hdr_end) begin
                    n_phase = (w_got_all || w_too_big) ? PH_DONE : PH_BODY;
                end else if (w_ovf) begin
                    n_phase = PH_DONE;
                end
            end
            PH_BODY: begin
                n_phase = (w_got_all || w_too_big) ? PH_DONE : PH_BODY;
            end
            default: begin
                n_phase = s_phase;
            end
        endcase
    end

    // Verdict for this word.
    always_comb begin
        w_verdict = V_IGNORED;
        case (s_phase)
            PH_HEADERS: begin
                if (w_hdr_end) begin
                    w_verdict = w_got_all ? V_COMPLETE :
                                (w_too_big ? V_TOO_LARGE : V_PENDING);
                end else begin
                    w_verdict = w_ovf ? V_HDR_OVF : V_PENDING;
                end
            end
            PH_BODY: begin
                w_verdict = w_got_all ? V_COMPLETE :
                            (w_too_big ? V_TOO_LARGE : V_PENDING);
            end
            default: begin
                w_verdict = V_IGNORED;
            end
        endcase
    end

    assign o_result.verdict       = w_verdict;
    assign o_result.header_length = n_bo;
    assign o_result.body_length   = n_lv;
    assign o_result.bytes_seen    = n_bt;

    // Request state registers, updated once per processed word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADERS;
            r_bt    <= 16'd0;
            r_cp    <= 2'd0;
            r_np    <= 4'd0;
            r_lp    <= LP_SEARCH;
            r_lv    <= 32'd0;
            r_bo    <= 16'd0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_bt    <= n_bt;
            r_cp    <= n_cp;
            r_np    <= n_np;
            r_lp    <= n_lp;
            r_lv    <= n_lv;
            r_bo    <= n_bo;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/http_request_framer_top.sv
// Top level of the HTTP request framer; depends on hrf_pkg and hrf_core.
// Each accepted word is held in the input register, processed by hrf_core when the output
// register is free or draining, and its result is registered for the master side.
// Throughput: one byte per cycle while the master side takes results; the input register
// lets a new byte enter while a finished result waits to be taken.
// Reset: i_rst_n is synchronous, active low; it clears the valid flags and request state and sets the limit to 4096.
`default_nettype none

module http_request_framer_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [15:0] i_cfg_wr_data,  // request_limit
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tuser,   // [0] first_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [71:0]      m_axis_tdata    // [2:0] verdict, [18:3] header_length,
                                             // [50:19] body_length, [66:51] bytes_seen,
                                             // [71:67] zero
);
    import hrf_pkg::*;

    logic [15:0] r_request_limit;
    logic        r_in_valid;
    t_in_item    r_in_item;
    logic        r_out_valid;
    t_result     r_out;
    logic        w_advance;
    t_result     w_result;

    // Process the held word when the output register is free or draining.
    assign w_advance     = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_advance;

    // Buffer limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_request_limit <= LIMIT_RESET;
        end else if (i_cfg_wr_en) begin
            r_request_limit <= i_cfg_wr_data;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item.data_byte  <= s_axis_tdata;
            r_in_item.first_byte <= s_axis_tuser;
        end
    end

    hrf_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in_item),
        .i_limit   (r_request_limit),
        .o_result  (w_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out.bytes_seen, r_out.body_length,
                            r_out.header_length, r_out.verdict};

    // A completed request has a recorded header end and has seen at least its header bytes.
    a_complete_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.verdict == V_COMPLETE) |->
        (r_out.header_length != 16'd0 && r_out.bytes_seen >= r_out.header_length))
        else $error("complete verdict without a header end");

    // An oversize request is only judged after the header end.
    a_too_large_after_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.verdict == V_TOO_LARGE) |-> (r_out.header_length != 16'd0))
        else $error("too-large verdict before the header end");

    // A header overflow means no header end was seen.
    a_overflow_no_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && r_out.verdict == V_HDR_OVF) |-> (r_out.header_length == 16'd0))
        else $error("header overflow with a header end recorded");

    // Every processed word leaves a result in the output register.
    a_advance_fills_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_advance |=> r_out_valid)
        else $error("processed word left no result");

endmodule

`default_nettype wire
